// File: rtl/omw_pkg.sv
package omw_pkg;

   // field widths
   localparam int CMD_W = 11;
   localparam int LIM_W = 10;
   localparam int OUT_W = 11;
   localparam int LANES = 3;

   // mixed wheel value before limiting: |w| <= 886 + 512 + 1024
   localparam int MIX_W = 13;
   localparam int MAG_W = 12;
   // |w| * limit, dividend of the scaling division
   localparam int NUM_W = MAG_W + LIM_W;
   // quotient bits of the scaling division, quotient never exceeds the limit
   localparam int DIV_STEPS = LIM_W;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(1000);

   // lane order inside the wheel arrays
   localparam int LANE_LEFT  = 0;
   localparam int LANE_RIGHT = 1;
   localparam int LANE_REAR  = 2;

   // floor(m / 1000) == (m * RECIP_1000) >> RECIP_SHIFT for every m below 2**20
   localparam int SIN60_PERMILLE = 866;
   localparam int RECIP_SHIFT = 30;
   localparam int RECIP_1000 = ((2 ** RECIP_SHIFT) + 999) / 1000;
   localparam int FMULT_W = 30;
   localparam logic [FMULT_W-1:0] FWD_MULT = FMULT_W'(SIN60_PERMILLE * RECIP_1000);
   localparam int FQ_W = 11;
   localparam int FPROD_W = FQ_W + FMULT_W;

   // classified transaction, front to back
   typedef struct packed {
      logic [LANES-1:0][NUM_W-1:0] num;
      logic [LANES-1:0]            neg;
      logic [LANES-1:0][OUT_W-1:0] raw;
      logic [MAG_W-1:0]            peak;
      logic                        scaled;
   } omw_item_type;

   // one divider stage
   typedef struct packed {
      logic [LANES-1:0][NUM_W-1:0] rem;
      logic [LANES-1:0][LIM_W-1:0] quo;
      logic [LANES-1:0]            neg;
      logic [LANES-1:0][OUT_W-1:0] raw;
      logic [MAG_W-1:0]            peak;
      logic                        scaled;
   } omw_div_type;

   function automatic logic [OUT_W-1:0] wheel_mag(input logic [OUT_W-1:0] v);
      logic [OUT_W-1:0] r;
      r = v[OUT_W-1] ? (~v + OUT_W'(1)) : v;
      return r;
   endfunction

endpackage

// File: rtl/omw_front.sv
module omw_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [omw_pkg::LIM_W-1:0]         limit,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [omw_pkg::CMD_W-1:0]  req_forward_cmd,
   input  logic signed [omw_pkg::CMD_W-1:0]  req_strafe_cmd,
   input  logic signed [omw_pkg::CMD_W-1:0]  req_turn_cmd,
   output logic                              item_valid,
   input  logic                              item_stall,
   output omw_pkg::omw_item_type             item
);
   import omw_pkg::*;

   logic s1_adv, s2_adv, s3_adv;

   logic s1_valid_ff, s2_valid_ff, s3_valid_ff;

   logic signed [FQ_W:0]    s1_fterm_ff, s1_fterm_in;
   logic signed [CMD_W-1:0] s1_sterm_ff, s1_sterm_in;
   logic signed [CMD_W-1:0] s1_str_ff;
   logic signed [CMD_W-1:0] s1_trn_ff;

   logic signed [MIX_W-1:0] s2_wheel_ff [LANES];
   logic signed [MIX_W-1:0] s2_wheel_in [LANES];

   omw_item_type s3_item_ff, s3_item_in;

   logic [CMD_W-1:0]   fwd_bits, fwd_mag, str_bits, str_mag, str_half;
   logic [FPROD_W-1:0] fwd_prod;
   logic [FQ_W-1:0]    fwd_quo;
   logic [FQ_W:0]      fwd_quo_ext;

   logic signed [MIX_W-1:0] f_ext, s_ext, st_ext, t_ext;

   logic [MIX_W-1:0] wheel_bits [LANES];
   logic [MIX_W-1:0] wheel_neg  [LANES];
   logic [MAG_W-1:0] wheel_mag  [LANES];
   logic [MAG_W-1:0] peak;

   assign s3_adv    = !s3_valid_ff || !item_stall;
   assign s2_adv    = !s2_valid_ff || s3_adv;
   assign s1_adv    = !s1_valid_ff || s2_adv;
   assign req_stall = !s1_adv;

   // stage 1: 0.866 term via reciprocal multiply, 0.5 term is a halving
   always_comb begin
      fwd_bits    = req_forward_cmd;
      fwd_mag     = fwd_bits[CMD_W-1] ? (~fwd_bits + CMD_W'(1)) : fwd_bits;
      fwd_prod    = FPROD_W'(fwd_mag) * FPROD_W'(FWD_MULT);
      fwd_quo     = fwd_prod[RECIP_SHIFT +: FQ_W];
      fwd_quo_ext = {1'b0, fwd_quo};
      s1_fterm_in = fwd_bits[CMD_W-1] ? $signed(~fwd_quo_ext + (FQ_W+1)'(1))
                                      : $signed(fwd_quo_ext);

      str_bits    = req_strafe_cmd;
      str_mag     = str_bits[CMD_W-1] ? (~str_bits + CMD_W'(1)) : str_bits;
      str_half    = str_mag >> 1;
      s1_sterm_in = str_bits[CMD_W-1] ? $signed(~str_half + CMD_W'(1))
                                      : $signed(str_half);
   end

   // stage 2: mix
   always_comb begin
      f_ext  = MIX_W'(s1_fterm_ff);
      s_ext  = MIX_W'(s1_sterm_ff);
      st_ext = MIX_W'(s1_str_ff);
      t_ext  = MIX_W'(s1_trn_ff);
      s2_wheel_in[LANE_LEFT]  = s_ext - f_ext - t_ext;
      s2_wheel_in[LANE_RIGHT] = s_ext + f_ext - t_ext;
      s2_wheel_in[LANE_REAR]  = -st_ext - t_ext;
   end

   // stage 3: magnitudes, peak, limit check and dividends
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         wheel_bits[i] = s2_wheel_ff[i];
         wheel_neg[i]  = ~wheel_bits[i] + MIX_W'(1);
         wheel_mag[i]  = wheel_bits[i][MIX_W-1] ? wheel_neg[i][MAG_W-1:0]
                                                : wheel_bits[i][MAG_W-1:0];
      end
      peak = wheel_mag[LANE_LEFT];
      if (wheel_mag[LANE_RIGHT] > peak) begin
         peak = wheel_mag[LANE_RIGHT];
      end
      if (wheel_mag[LANE_REAR] > peak) begin
         peak = wheel_mag[LANE_REAR];
      end
      for (int i = 0; i < LANES; i++) begin
         s3_item_in.num[i] = NUM_W'(wheel_mag[i]) * NUM_W'(limit);
         s3_item_in.neg[i] = wheel_bits[i][MIX_W-1];
         s3_item_in.raw[i] = wheel_bits[i][OUT_W-1:0];
      end
      s3_item_in.peak   = peak;
      s3_item_in.scaled = peak > MAG_W'(limit);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_adv) s1_valid_ff <= req_valid;
         if (s2_adv) s2_valid_ff <= s1_valid_ff;
         if (s3_adv) s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && req_valid) begin
         s1_fterm_ff <= s1_fterm_in;
         s1_sterm_ff <= s1_sterm_in;
         s1_str_ff   <= req_strafe_cmd;
         s1_trn_ff   <= req_turn_cmd;
      end
      if (s2_adv && s1_valid_ff) begin
         s2_wheel_ff <= s2_wheel_in;
      end
      if (s3_adv && s2_valid_ff) begin
         s3_item_ff <= s3_item_in;
      end
   end

   assign item_valid = s3_valid_ff;
   assign item       = s3_item_ff;

endmodule

// File: rtl/omw_queue.sv
module omw_queue #(
   parameter int Depth = omw_pkg::QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_stall,
   input  omw_pkg::omw_item_type in_item,
   output logic                  out_valid,
   input  logic                  out_stall,
   output omw_pkg::omw_item_type out_item
);
   import omw_pkg::*;

   localparam int IDX_W = $clog2(Depth);
   localparam int CNT_W = $clog2(Depth + 1);

   omw_item_type     slot_ff [Depth];
   logic [IDX_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign in_stall  = (count_ff == CNT_W'(Depth));
   assign out_valid = (count_ff != '0);
   assign out_item  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && !in_stall;
   assign pop       = out_valid && !out_stall;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == IDX_W'(Depth - 1)) ? '0 : wr_ptr_ff + IDX_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == IDX_W'(Depth - 1)) ? '0 : rd_ptr_ff + IDX_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

// File: rtl/omw_back.sv
module omw_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              item_valid,
   output logic                              item_stall,
   input  omw_pkg::omw_item_type             item,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [omw_pkg::OUT_W-1:0]  rsp_left_wheel,
   output logic signed [omw_pkg::OUT_W-1:0]  rsp_right_wheel,
   output logic signed [omw_pkg::OUT_W-1:0]  rsp_rear_wheel,
   output logic                              rsp_was_scaled
);
   import omw_pkg::*;

   localparam int LAST = DIV_STEPS - 1;

   logic [DIV_STEPS-1:0] stage_valid_ff;
   logic [DIV_STEPS-1:0] stage_adv;
   omw_div_type          stage_ff  [DIV_STEPS];
   omw_div_type          stage_src [DIV_STEPS];
   omw_div_type          stage_in  [DIV_STEPS];

   logic                    out_adv;
   logic                    rsp_valid_ff;
   logic [OUT_W-1:0]        wheel_in [LANES];
   logic [OUT_W-1:0]        wheel_ff [LANES];
   logic                    scaled_ff;
   logic [OUT_W-1:0]        quo_ext  [LANES];

   assign out_adv = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      stage_adv[LAST] = !stage_valid_ff[LAST] || out_adv;
      for (int s = LAST - 1; s >= 0; s--) begin
         stage_adv[s] = !stage_valid_ff[s] || stage_adv[s+1];
      end
   end

   assign item_stall = !stage_adv[0];

   // restoring divider, one quotient bit per stage, msb first
   for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
      localparam int Bit = DIV_STEPS - 1 - s;

      if (s == 0) begin : g_load
         always_comb begin
            stage_src[s].rem    = item.num;
            stage_src[s].quo    = '0;
            stage_src[s].neg    = item.neg;
            stage_src[s].raw    = item.raw;
            stage_src[s].peak   = item.peak;
            stage_src[s].scaled = item.scaled;
         end
         always_ff @(posedge clock) begin
            if (reset) begin
               stage_valid_ff[s] <= 1'b0;
            end else if (stage_adv[s]) begin
               stage_valid_ff[s] <= item_valid;
            end
         end
      end else begin : g_chain
         assign stage_src[s] = stage_ff[s-1];
         always_ff @(posedge clock) begin
            if (reset) begin
               stage_valid_ff[s] <= 1'b0;
            end else if (stage_adv[s]) begin
               stage_valid_ff[s] <= stage_valid_ff[s-1];
            end
         end
      end

      always_comb begin
         logic [NUM_W-1:0] trial;
         trial = NUM_W'(stage_src[s].peak) << Bit;
         stage_in[s] = stage_src[s];
         for (int i = 0; i < LANES; i++) begin
            if (stage_src[s].rem[i] >= trial) begin
               stage_in[s].rem[i]      = stage_src[s].rem[i] - trial;
               stage_in[s].quo[i][Bit] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (stage_adv[s]) begin
            stage_ff[s] <= stage_in[s];
         end
      end
   end

   // apply the sign, or pass the mix through when no limiting was needed
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         quo_ext[i]  = {1'b0, stage_ff[LAST].quo[i]};
         wheel_in[i] = !stage_ff[LAST].scaled ? stage_ff[LAST].raw[i] :
                       stage_ff[LAST].neg[i]  ? (~quo_ext[i] + OUT_W'(1)) : quo_ext[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_adv) begin
         rsp_valid_ff <= stage_valid_ff[LAST];
      end
   end

   always_ff @(posedge clock) begin
      if (out_adv && stage_valid_ff[LAST]) begin
         wheel_ff  <= wheel_in;
         scaled_ff <= stage_ff[LAST].scaled;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_left_wheel  = wheel_ff[LANE_LEFT];
   assign rsp_right_wheel = wheel_ff[LANE_RIGHT];
   assign rsp_rear_wheel  = wheel_ff[LANE_REAR];
   assign rsp_was_scaled  = scaled_ff;

endmodule

// File: rtl/omni_wheel_mix_normalize_top.sv
// channel   direction  handshake             payload
// req       in         req_valid/req_stall   forward, strafe, turn commands
// rsp       out        rsp_valid/rsp_stall   left, right, rear wheels, was_scaled
// csr       in         csr_write_en          drive limit, 10 bits
//
// one transaction per cycle sustained while rsp_stall stays low; a result passes through
// 3 front stages (mix multiply, mix adds, peak and dividend multiply), the queue,
// a 10-stage restoring divider, and the output register
// reset clears all valid flags and the queue and sets the drive limit to 1000
// rsp_stall holds the output register, then backs up the divider, the queue and the
// front; req_stall rises only once the first front stage cannot move
module omni_wheel_mix_normalize_top #(
   parameter int QueueDepth = omw_pkg::QUEUE_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic [omw_pkg::LIM_W-1:0]         csr_write_data,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [omw_pkg::CMD_W-1:0]  req_forward_cmd,
   input  logic signed [omw_pkg::CMD_W-1:0]  req_strafe_cmd,
   input  logic signed [omw_pkg::CMD_W-1:0]  req_turn_cmd,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [omw_pkg::OUT_W-1:0]  rsp_left_wheel,
   output logic signed [omw_pkg::OUT_W-1:0]  rsp_right_wheel,
   output logic signed [omw_pkg::OUT_W-1:0]  rsp_rear_wheel,
   output logic                              rsp_was_scaled
);
   import omw_pkg::*;

   logic [LIM_W-1:0] limit_ff, limit_in;

   logic         front_valid, front_stall;
   omw_item_type front_item;
   logic         back_valid, back_stall;
   omw_item_type back_item;

   logic [OUT_W-1:0] lim_ext;

   assign limit_in = csr_write_en ? csr_write_data : limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   omw_front u_front (
      .clock           (clock),
      .reset           (reset),
      .limit           (limit_ff),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_forward_cmd (req_forward_cmd),
      .req_strafe_cmd  (req_strafe_cmd),
      .req_turn_cmd    (req_turn_cmd),
      .item_valid      (front_valid),
      .item_stall      (front_stall),
      .item            (front_item)
   );

   omw_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_stall  (front_stall),
      .in_item   (front_item),
      .out_valid (back_valid),
      .out_stall (back_stall),
      .out_item  (back_item)
   );

   omw_back u_back (
      .clock           (clock),
      .reset           (reset),
      .item_valid      (back_valid),
      .item_stall      (back_stall),
      .item            (back_item),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_left_wheel  (rsp_left_wheel),
      .rsp_right_wheel (rsp_right_wheel),
      .rsp_rear_wheel  (rsp_rear_wheel),
      .rsp_was_scaled  (rsp_was_scaled)
   );

   assign lim_ext = OUT_W'(limit_ff);

   // every delivered wheel stays within the limit
   a_within_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (wheel_mag(rsp_left_wheel) <= lim_ext) &&
                    (wheel_mag(rsp_right_wheel) <= lim_ext) &&
                    (wheel_mag(rsp_rear_wheel) <= lim_ext))
      else $error("wheel command above drive limit");

   // the peak wheel lands exactly on the limit after scaling
   a_peak_on_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_was_scaled |-> (wheel_mag(rsp_left_wheel) == lim_ext) ||
                                      (wheel_mag(rsp_right_wheel) == lim_ext) ||
                                      (wheel_mag(rsp_rear_wheel) == lim_ext))
      else $error("scaled transaction has no wheel at the limit");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

// File: tb/tb_omni_wheel_mix_normalize_top.sv
`timescale 1ns / 1ps

module tb_omni_wheel_mix_normalize_top;

   localparam int SIN60_PERMILLE = 866;
   localparam int COS60_PERMILLE = 500;
   localparam int PERMILLE       = 1000;
   localparam int SETTLE_CYCLES  = 24;
   localparam int PHASE_ITEMS    = 150;

   typedef struct packed {
      logic [omw_pkg::LANES-1:0][omw_pkg::OUT_W-1:0] wheel;
      logic                                          scaled;
   } wheel_set_type;

   class wheel_mix_scoreboard_type;
      logic [omw_pkg::LIM_W-1:0] drive_limit;
      wheel_set_type             expected_wheels[$];
      string                     lane_name[omw_pkg::LANES];
      int                        errors;

      function new();
         drive_limit = omw_pkg::LIMIT_RESET;
         errors = 0;
         lane_name[omw_pkg::LANE_LEFT]  = "left_wheel";
         lane_name[omw_pkg::LANE_RIGHT] = "right_wheel";
         lane_name[omw_pkg::LANE_REAR]  = "rear_wheel";
      endfunction

      function void set_limit(input logic [omw_pkg::LIM_W-1:0] value);
         drive_limit = value;
      endfunction

      function int pending();
         return expected_wheels.size();
      endfunction

      // mix into three wheels, then scale down proportionally past the limit
      function wheel_set_type mix_wheels(input logic signed [omw_pkg::CMD_W-1:0] fwd,
                                         input logic signed [omw_pkg::CMD_W-1:0] str,
                                         input logic signed [omw_pkg::CMD_W-1:0] trn);
         int            fterm;
         int            sterm;
         int            lim;
         int            peak;
         int            mag;
         int            w[omw_pkg::LANES];
         wheel_set_type r;
         fterm = (SIN60_PERMILLE * int'(fwd)) / PERMILLE;
         sterm = (COS60_PERMILLE * int'(str)) / PERMILLE;
         w[omw_pkg::LANE_LEFT]  = -fterm + sterm - int'(trn);
         w[omw_pkg::LANE_RIGHT] = fterm + sterm - int'(trn);
         w[omw_pkg::LANE_REAR]  = -int'(str) - int'(trn);
         lim = int'(drive_limit);
         peak = 0;
         for (int i = 0; i < omw_pkg::LANES; i++) begin
            mag = (w[i] < 0) ? -w[i] : w[i];
            if (mag > peak) peak = mag;
         end
         r.scaled = (peak > lim);
         for (int i = 0; i < omw_pkg::LANES; i++) begin
            if (r.scaled) w[i] = (w[i] * lim) / peak;
            r.wheel[i] = omw_pkg::OUT_W'(w[i]);
         end
         return r;
      endfunction

      function void note_command(input logic signed [omw_pkg::CMD_W-1:0] fwd,
                                 input logic signed [omw_pkg::CMD_W-1:0] str,
                                 input logic signed [omw_pkg::CMD_W-1:0] trn);
         expected_wheels.push_back(mix_wheels(fwd, str, trn));
      endfunction

      function void check_wheels(input wheel_set_type got);
         wheel_set_type exp;
         if (expected_wheels.size() == 0) begin
            $display("%0t: unexpected result left=%0d right=%0d rear=%0d scaled=%0d", $time,
                     $signed(got.wheel[omw_pkg::LANE_LEFT]),
                     $signed(got.wheel[omw_pkg::LANE_RIGHT]),
                     $signed(got.wheel[omw_pkg::LANE_REAR]), got.scaled);
            errors++;
            return;
         end
         exp = expected_wheels.pop_front();
         for (int i = 0; i < omw_pkg::LANES; i++) begin
            if (got.wheel[i] !== exp.wheel[i]) begin
               $display("%0t: %s expected %0d actual %0d", $time, lane_name[i],
                        $signed(exp.wheel[i]), $signed(got.wheel[i]));
               errors++;
            end
         end
         if (got.scaled !== exp.scaled) begin
            $display("%0t: was_scaled expected %0d actual %0d", $time, exp.scaled, got.scaled);
            errors++;
         end
      endfunction
   endclass

   logic                               clock = 1'b0;
   logic                               reset;
   logic                               csr_write_en;
   logic [omw_pkg::LIM_W-1:0]          csr_write_data;
   logic                               req_valid;
   logic                               req_stall;
   logic signed [omw_pkg::CMD_W-1:0]   req_forward_cmd;
   logic signed [omw_pkg::CMD_W-1:0]   req_strafe_cmd;
   logic signed [omw_pkg::CMD_W-1:0]   req_turn_cmd;
   logic                               rsp_valid;
   logic                               rsp_stall;
   logic signed [omw_pkg::OUT_W-1:0]   rsp_left_wheel;
   logic signed [omw_pkg::OUT_W-1:0]   rsp_right_wheel;
   logic signed [omw_pkg::OUT_W-1:0]   rsp_rear_wheel;
   logic                               rsp_was_scaled;

   wheel_mix_scoreboard_type wheel_sb;
   wheel_set_type            seen_wheels;
   bit                       no_idle = 1'b0;
   int                       stall_left = 0;
   int                       stall_pick;

   omni_wheel_mix_normalize_top DUT (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_write_data  (csr_write_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_forward_cmd (req_forward_cmd),
      .req_strafe_cmd  (req_strafe_cmd),
      .req_turn_cmd    (req_turn_cmd),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_left_wheel  (rsp_left_wheel),
      .rsp_right_wheel (rsp_right_wheel),
      .rsp_rear_wheel  (rsp_rear_wheel),
      .rsp_was_scaled  (rsp_was_scaled)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver back-pressure: mostly short bursts, now and then a long one
   always @(posedge clock) begin
      if (no_idle) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         stall_pick = $urandom_range(0, 99);
         if (stall_pick < 70) begin
            rsp_stall <= 1'b0;
         end else if (stall_pick < 95) begin
            stall_left = $urandom_range(0, 2);
            rsp_stall <= 1'b1;
         end else begin
            stall_left = $urandom_range(15, 50);
            rsp_stall <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         seen_wheels.wheel[omw_pkg::LANE_LEFT]  = rsp_left_wheel;
         seen_wheels.wheel[omw_pkg::LANE_RIGHT] = rsp_right_wheel;
         seen_wheels.wheel[omw_pkg::LANE_REAR]  = rsp_rear_wheel;
         seen_wheels.scaled = rsp_was_scaled;
         wheel_sb.check_wheels(seen_wheels);
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic signed [omw_pkg::CMD_W-1:0] rand_cmd();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) begin
         case ($urandom_range(0, 6))
            0: return -omw_pkg::CMD_W'(1024);
            1: return -omw_pkg::CMD_W'(1000);
            2: return -omw_pkg::CMD_W'(1);
            3: return '0;
            4: return omw_pkg::CMD_W'(1);
            5: return omw_pkg::CMD_W'(1000);
            default: return omw_pkg::CMD_W'(1023);
         endcase
      end
      if (r < 30) return omw_pkg::CMD_W'(int'($urandom_range(0, 400)) - 200);
      if (r < 75) return omw_pkg::CMD_W'(int'($urandom_range(0, 2000)) - 1000);
      return omw_pkg::CMD_W'($urandom);
   endfunction

   task automatic send_command(input logic signed [omw_pkg::CMD_W-1:0] fwd,
                               input logic signed [omw_pkg::CMD_W-1:0] str,
                               input logic signed [omw_pkg::CMD_W-1:0] trn);
      int gap;
      req_valid       <= 1'b1;
      req_forward_cmd <= fwd;
      req_strafe_cmd  <= str;
      req_turn_cmd    <= trn;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      wheel_sb.note_command(fwd, str, trn);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_random(input int count);
      repeat (count) send_command(rand_cmd(), rand_cmd(), rand_cmd());
   endtask

   // hold the sender until every outstanding transaction has come back
   task automatic drain_results();
      if (req_valid) req_valid <= 1'b0;
      while (wheel_sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_drive_limit(input logic [omw_pkg::LIM_W-1:0] value);
      drain_results();
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      wheel_sb.set_limit(value);
   endtask

   task automatic send_corners();
      send_command(-11'sd1024, -11'sd1024, -11'sd1024);
      send_command(11'sd1023, 11'sd1023, 11'sd1023);
      send_command(11'sd0, 11'sd0, 11'sd0);
      send_command(11'sd1, -11'sd1, 11'sd0);
   endtask

   initial begin
      wheel_sb = new();
      reset           <= 1'b1;
      csr_write_en    <= 1'b0;
      csr_write_data  <= '0;
      req_valid       <= 1'b0;
      req_forward_cmd <= '0;
      req_strafe_cmd  <= '0;
      req_turn_cmd    <= '0;
      rsp_stall       <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed part at the reset limit
      send_command(11'sd0, 11'sd0, 11'sd0);
      send_command(11'sd1000, 11'sd0, 11'sd0);
      send_command(-11'sd1000, 11'sd0, 11'sd0);
      send_command(11'sd0, 11'sd1000, 11'sd0);
      send_command(11'sd0, -11'sd1000, 11'sd0);
      send_command(11'sd0, 11'sd0, 11'sd1000);   // peak equals the limit, no scaling
      send_command(11'sd0, 11'sd0, -11'sd1000);
      send_command(11'sd0, 11'sd0, 11'sd1001);   // one over the limit
      send_command(11'sd1000, 11'sd1000, 11'sd1000);
      send_command(-11'sd1000, -11'sd1000, -11'sd1000);
      send_command(11'sd1000, -11'sd1000, 11'sd1000);
      send_command(11'sd1023, 11'sd1023, 11'sd1023);
      send_command(-11'sd1024, -11'sd1024, -11'sd1024);
      send_command(-11'sd1024, 11'sd1023, -11'sd1024);
      // truncation toward zero on odd inputs
      send_command(11'sd1, 11'sd1, 11'sd0);
      send_command(-11'sd1, -11'sd1, 11'sd0);
      send_command(11'sd7, -11'sd3, 11'sd0);
      send_command(-11'sd7, 11'sd3, 11'sd0);
      send_command(11'sd577, 11'sd333, -11'sd999);
      send_command(-11'sd577, -11'sd333, 11'sd999);

      send_random(PHASE_ITEMS);
      drain_results();
      send_random(PHASE_ITEMS);

      set_drive_limit(omw_pkg::LIM_W'(1));
      send_corners();
      send_random(PHASE_ITEMS);

      // zero limit collapses every nonzero mix to all zeros
      set_drive_limit('0);
      send_corners();
      send_random(PHASE_ITEMS);

      set_drive_limit(omw_pkg::LIM_W'(1023));
      send_corners();
      send_random(PHASE_ITEMS);

      set_drive_limit(omw_pkg::LIM_W'(500));
      send_random(PHASE_ITEMS);

      set_drive_limit(omw_pkg::LIM_W'($urandom_range(2, 999)));
      send_random(PHASE_ITEMS);

      // back-to-back stretch with no stalls at all
      set_drive_limit(omw_pkg::LIM_W'(1000));
      no_idle = 1'b1;
      send_random(PHASE_ITEMS);
      drain_results();
      no_idle = 1'b0;

      if (wheel_sb.errors == 0 && wheel_sb.pending() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule

// File: filelist.f
rtl/omw_pkg.sv
rtl/omw_front.sv
rtl/omw_queue.sv
rtl/omw_back.sv
rtl/omni_wheel_mix_normalize_top.sv
tb/tb_omni_wheel_mix_normalize_top.sv
